// ===== rtl/core/tfrcpu_pkg.sv =====
// ----------------------------------------------------------------------------
// tfrcpu_pkg
// Shared widths, item kinds and opcodes for the four-register CPU step core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfrcpu_pkg;

   localparam int unsigned TFRCPU_MEM_DEPTH = 256;
   localparam int unsigned STORE_SPAN       = 256;
   localparam int unsigned BYTE_W           = 8;
   localparam int unsigned REQ_DATA_W       = 24;
   localparam int unsigned RSP_DATA_W       = 48;

   localparam logic KIND_EXEC    = 1'b0;
   localparam logic KIND_PRELOAD = 1'b1;

   localparam logic [BYTE_W-1:0] NIB_HI = 8'd240;
   localparam logic [BYTE_W-1:0] NIB_LO = 8'd15;

   typedef enum logic [2:0] {
      OPC_ADD   = 3'd0,
      OPC_SUB   = 3'd1,
      OPC_LOAD  = 3'd2,
      OPC_STORE = 3'd3,
      OPC_JLEZ  = 3'd4,
      OPC_JALR  = 3'd5,
      OPC_HALT  = 3'd7
   } opc_type;

   function automatic logic [BYTE_W-1:0] pick_reg(
      input logic [1:0]        idx,
      input logic [BYTE_W-1:0] r0,
      input logic [BYTE_W-1:0] r1,
      input logic [BYTE_W-1:0] r2,
      input logic [BYTE_W-1:0] r3
   );
      logic [BYTE_W-1:0] v;
      case (idx)
         2'd0:    v = r0;
         2'd1:    v = r1;
         2'd2:    v = r2;
         default: v = r3;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tiny_four_register_cpu_step_core.sv =====
// ----------------------------------------------------------------------------
// tiny_four_register_cpu_step_core
// One instruction or data preload per transfer on a four-register 8-bit CPU.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit first)                          | tuser
// req_    | in  | instr[7:0], mem_addr[15:8], mem_data[23:16]     | op
// rsp_    | out | next_pc, reg_a, reg_b, reg_c, reg_d, halted     | none
//
// An item enters an item register while the data store is read at its
// address (registered read, forwarded past a write in the same cycle); it
// executes once the result register is free or taken, its result registered.
// One item per cycle while rsp_tready is high. Reset clears pc, registers,
// halt flag and a valid bit per store entry, so no clearing pass is needed.
// A stalled result holds one item in the item register, then req_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tiny_four_register_cpu_step_core
   import tfrcpu_pkg::*;
#(
   parameter int unsigned MEM_DEPTH = TFRCPU_MEM_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // instr, mem_addr, mem_data
   input  wire logic                  req_tuser,   // op
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata    // next_pc, reg_a..reg_d, halted
);

   localparam int unsigned AddrWidth = $clog2(MEM_DEPTH);

   typedef logic [STORE_SPAN-1:0][AddrWidth-1:0] wrap_tbl_type;

   function automatic wrap_tbl_type build_wrap();
      wrap_tbl_type t;
      for (int i = 0; i < STORE_SPAN; i++) begin
         t[i] = AddrWidth'(i % MEM_DEPTH);
      end
      return t;
   endfunction

   localparam wrap_tbl_type WrapTbl = build_wrap();

   logic                 item_vld_ff, item_vld_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [BYTE_W-1:0]    pc_ff, pc_in;
   logic [BYTE_W-1:0]    ra_ff, ra_in, rb_ff, rb_in, rc_ff, rc_in, rd_ff, rd_in;
   logic                 halt_ff, halt_in;
   logic [MEM_DEPTH-1:0] vld_ff;

   logic [BYTE_W-1:0]    instr_ff;
   logic                 op_ff;
   logic [BYTE_W-1:0]    data_ff;
   logic [AddrWidth-1:0] addr_ff;
   logic [BYTE_W-1:0]    rdata_ff;
   logic                 rvld_ff;
   logic                 byp_ff;
   logic [BYTE_W-1:0]    bypd_ff;

   logic [BYTE_W-1:0]    mem [MEM_DEPTH];

   logic                 req_accept;
   logic                 exec_fire;
   logic                 mem_we;
   logic [BYTE_W-1:0]    mem_wdata;
   logic                 rf_we;
   logic [1:0]           rf_widx;
   logic [BYTE_W-1:0]    rf_wval;
   logic [1:0]           x_rd;
   logic [1:0]           x_rs;
   logic [BYTE_W-1:0]    rd_val;
   logic [BYTE_W-1:0]    rs_val;
   logic [BYTE_W-1:0]    load_val;
   logic [BYTE_W-1:0]    raddr_raw;
   logic [AddrWidth-1:0] raddr;

   assign exec_fire  = item_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !item_vld_ff || exec_fire;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {7'd0, halt_ff, rd_ff, rc_ff, rb_ff, ra_ff, pc_ff};

   assign x_rd     = instr_ff[7] ? instr_ff[5:4] : instr_ff[3:2];
   assign x_rs     = instr_ff[1:0];
   assign rd_val   = pick_reg(x_rd, ra_ff, rb_ff, rc_ff, rd_ff);
   assign rs_val   = pick_reg(x_rs, ra_ff, rb_ff, rc_ff, rd_ff);
   assign load_val = byp_ff ? bypd_ff : (rvld_ff ? rdata_ff : '0);

   always_comb begin
      pc_in     = pc_ff;
      halt_in   = halt_ff;
      mem_we    = 1'b0;
      mem_wdata = (op_ff == KIND_PRELOAD) ? data_ff : rd_val;
      rf_we     = 1'b0;
      rf_widx   = x_rd;
      rf_wval   = '0;
      if (exec_fire && !halt_ff) begin
         if (op_ff == KIND_PRELOAD) begin
            mem_we = 1'b1;
         end else if (instr_ff[7]) begin
            rf_we = 1'b1;
            if (instr_ff[6]) begin
               rf_wval = (rd_val & NIB_HI) | {4'd0, instr_ff[3:0]};
            end else begin
               rf_wval = {instr_ff[3:0], 4'd0} | (rd_val & NIB_LO);
            end
            pc_in = pc_ff + 8'd1;
         end else begin
            case (instr_ff[6:4])
               OPC_ADD: begin
                  rf_we   = 1'b1;
                  rf_wval = rd_val + rs_val;
                  pc_in   = pc_ff + 8'd1;
               end
               OPC_SUB: begin
                  rf_we   = 1'b1;
                  rf_wval = rd_val - rs_val;
                  pc_in   = pc_ff + 8'd1;
               end
               OPC_LOAD: begin
                  rf_we   = 1'b1;
                  rf_wval = load_val;
                  pc_in   = pc_ff + 8'd1;
               end
               OPC_STORE: begin
                  mem_we = 1'b1;
                  pc_in  = pc_ff + 8'd1;
               end
               OPC_JLEZ: begin
                  pc_in = (rs_val == 8'd0) ? rd_val : pc_ff + 8'd1;
               end
               OPC_JALR: begin
                  rf_we   = 1'b1;
                  rf_widx = x_rs;
                  rf_wval = pc_ff + 8'd2;
                  pc_in   = rd_val;
               end
               OPC_HALT: begin
                  halt_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
      ra_in = (rf_we && rf_widx == 2'd0) ? rf_wval : ra_ff;
      rb_in = (rf_we && rf_widx == 2'd1) ? rf_wval : rb_ff;
      rc_in = (rf_we && rf_widx == 2'd2) ? rf_wval : rc_ff;
      rd_in = (rf_we && rf_widx == 2'd3) ? rf_wval : rd_ff;
   end

   // read address of the arriving item sees the state after the executing one
   assign raddr_raw = (req_tuser == KIND_PRELOAD) ? req_tdata[15:8]
                    : pick_reg(req_tdata[1:0], ra_in, rb_in, rc_in, rd_in);
   assign raddr     = WrapTbl[raddr_raw];

   always_comb begin
      item_vld_in = item_vld_ff;
      if (req_accept) begin
         item_vld_in = 1'b1;
      end else if (exec_fire) begin
         item_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (exec_fire) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         pc_ff       <= '0;
         ra_ff       <= '0;
         rb_ff       <= '0;
         rc_ff       <= '0;
         rd_ff       <= '0;
         halt_ff     <= 1'b0;
         vld_ff      <= '0;
      end else begin
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         pc_ff       <= pc_in;
         ra_ff       <= ra_in;
         rb_ff       <= rb_in;
         rc_ff       <= rc_in;
         rd_ff       <= rd_in;
         halt_ff     <= halt_in;
         if (mem_we) begin
            vld_ff[addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         instr_ff <= req_tdata[7:0];
         op_ff    <= req_tuser;
         data_ff  <= req_tdata[23:16];
         addr_ff  <= raddr;
         rvld_ff  <= vld_ff[raddr];
         byp_ff   <= mem_we && (addr_ff == raddr);
         bypd_ff  <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      if (req_accept) begin
         rdata_ff <= mem[raddr];
      end
   end

   a_halt_sticky : assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff)
      else $error("halt flag cleared without reset");

   a_halt_freeze : assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> $stable(pc_ff) && $stable(ra_ff) && $stable(rb_ff)
                  && $stable(rc_ff) && $stable(rd_ff))
      else $error("state changed while halted");

   a_fire_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_vld_ff)
      else $error("executed item produced no result");

   a_item_hold : assert property (@(posedge clock) disable iff (reset)
      item_vld_ff && !exec_fire |=> item_vld_ff && $stable(instr_ff)
                                    && $stable(addr_ff))
      else $error("waiting item lost or changed");

endmodule

`default_nettype wire
